FILE: design/assert_macros.svh
// Assertion macros used by the voice slot allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define VBSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define VBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/vbss_pkg.sv
// Package for the voice slot allocator: constants and the slot entry type.
`default_nettype none

package vbss_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int PRIO_W  = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] STREAM_LIMIT_RST = 5'd4;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic              in_use;
        logic              streaming;
        logic              secondary;
        logic [PRIO_W-1:0] priority_val;
    } slot_entry_t;

endpackage

`default_nettype wire

FILE: design/vbss_slot_table.sv
// Voice slot table: flag bits in flops, priorities in a memory, one registered read port.
`default_nettype none

module vbss_slot_table #(
    parameter int NUM_SLOTS = vbss_pkg::NUM_SLOTS_DEF,
    localparam int IDX_W = $clog2(NUM_SLOTS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire vbss_pkg::slot_entry_t wr_data,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output vbss_pkg::slot_entry_t     rd_data
);
    import vbss_pkg::*;

    logic [NUM_SLOTS-1:0] use_reg;
    logic [NUM_SLOTS-1:0] stream_reg;
    logic [NUM_SLOTS-1:0] second_reg;
    logic [PRIO_W-1:0]    prio_mem [NUM_SLOTS];

    logic                 rd_use_reg;
    logic                 rd_stream_reg;
    logic                 rd_second_reg;
    logic [PRIO_W-1:0]    rd_prio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg       <= '0;
            stream_reg    <= '0;
            second_reg    <= '0;
            rd_use_reg    <= 1'b0;
            rd_stream_reg <= 1'b0;
            rd_second_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                use_reg[wr_addr]    <= wr_data.in_use;
                stream_reg[wr_addr] <= wr_data.streaming;
                second_reg[wr_addr] <= wr_data.secondary;
            end
            if (rd_en)
            begin
                rd_use_reg    <= use_reg[rd_addr];
                rd_stream_reg <= stream_reg[rd_addr];
                rd_second_reg <= second_reg[rd_addr];
            end
        end
    end

    // priority of a free slot is never consulted, so the memory needs no clear
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[wr_addr] <= wr_data.priority_val;
        end
        if (rd_en)
        begin
            rd_prio_reg <= prio_mem[rd_addr];
        end
    end

    assign rd_data.in_use       = rd_use_reg;
    assign rd_data.streaming    = rd_stream_reg;
    assign rd_data.secondary    = rd_second_reg;
    assign rd_data.priority_val = rd_prio_reg;

endmodule

`default_nettype wire

FILE: design/voice_buffer_steal_select_top.sv
// Voice slot allocator top level: slot writes, free-slot search and priority stealing.
`default_nettype none
`include "assert_macros.svh"

// A write word updates one slot entry, and its result state loads an all-zero
// result. A request word reads the slot table one slot per cycle through a single
// priority comparator, then uses the same comparator for two decision steps; it
// passes through the scan, last, compare and result states in that order.
// in_stall is high from acceptance until the result is loaded into the output
// register; a finished result may wait there while the next word is taken.
module voice_buffer_steal_select_top #(
    parameter int NUM_SLOTS = vbss_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_we,
    input  wire logic [vbss_pkg::LIMIT_W-1:0]   cfg_wdata,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           op,
    input  wire logic [vbss_pkg::INDEX_W-1:0]   slot_index,
    input  wire logic                           slot_in_use,
    input  wire logic [vbss_pkg::PRIO_W-1:0]    slot_priority,
    input  wire logic                           slot_streaming,
    input  wire logic                           slot_group_secondary,
    input  wire logic [vbss_pkg::PRIO_W-1:0]    request_priority,
    input  wire logic                           request_streaming,
    input  wire logic                           request_required,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                slot_found,
    output logic [vbss_pkg::INDEX_W-1:0]        chosen_slot,
    output logic [vbss_pkg::COUNT_W-1:0]        used_count
);
    import vbss_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] ALL_SLOTS = CNT_W'(NUM_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_CMP,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic                is_write_reg;
    logic [PRIO_W-1:0]   req_prio_reg;
    logic                req_stream_reg;
    logic                req_required_reg;

    logic [IDX_W-1:0]    scan_idx_reg;
    logic                pipe_valid_reg;
    logic [IDX_W-1:0]    pipe_idx_reg;

    logic                has_free_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                has_res_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic [PRIO_W-1:0]   res_prio_reg;
    logic                has_str_reg;
    logic [IDX_W-1:0]    str_idx_reg;
    logic [PRIO_W-1:0]   str_prio_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    str_cnt_reg;
    logic                res_ge_str_reg;

    logic                out_valid_reg;
    logic                found_reg;
    logic [INDEX_W-1:0]  chosen_reg;
    logic [COUNT_W-1:0]  used_out_reg;

    logic                in_accept;
    logic                tbl_wr_en;
    slot_entry_t         tbl_wr_data;
    logic                tbl_rd_en;
    slot_entry_t         rd_entry;
    logic                rd_resident;

    logic [PRIO_W-1:0]   cmp_a;
    logic [PRIO_W-1:0]   cmp_b;
    logic                cmp_lt;
    logic [PRIO_W-1:0]   cand_prio;

    logic                table_full;
    logic                stream_hit;
    logic                sel_str;
    logic                dec_found;
    logic [IDX_W-1:0]    dec_idx;
    logic                out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign tbl_wr_en = in_accept && (op == OP_WRITE) && (int'(slot_index) < NUM_SLOTS);
    assign tbl_wr_data.in_use       = slot_in_use;
    assign tbl_wr_data.streaming    = slot_streaming;
    assign tbl_wr_data.secondary    = slot_group_secondary;
    assign tbl_wr_data.priority_val = slot_priority;
    assign tbl_rd_en = (state_reg == ST_SCAN);

    vbss_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (IDX_W'(slot_index)),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_entry)
    );

    assign rd_resident = !rd_entry.streaming || rd_entry.secondary;
    assign table_full  = (used_reg == ALL_SLOTS);
    assign stream_hit  = req_stream_reg && (int'(str_cnt_reg) == int'(limit_reg));
    assign sel_str     = !has_res_reg || (has_str_reg && res_ge_str_reg);
    assign out_free    = !out_valid_reg || !out_stall;

    // candidate priority for the final compare against the request
    always_comb
    begin
        priority if (req_required_reg && !has_free_reg && table_full)
            cand_prio = sel_str ? str_prio_reg : res_prio_reg;
        else if (stream_hit)
            cand_prio = str_prio_reg;
        else
            cand_prio = res_prio_reg;
    end

    // shared comparator
    always_comb
    begin
        unique case (state_reg)
            ST_SCAN, ST_LAST:
            begin
                cmp_a = rd_entry.priority_val;
                cmp_b = rd_resident ? res_prio_reg : str_prio_reg;
            end
            ST_CMP:
            begin
                cmp_a = res_prio_reg;
                cmp_b = str_prio_reg;
            end
            default:
            begin
                cmp_a = cand_prio;
                cmp_b = req_prio_reg;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    always_comb
    begin
        priority if (req_required_reg && has_free_reg)
        begin
            dec_found = 1'b1;
            dec_idx   = free_idx_reg;
        end
        else if (req_required_reg && table_full)
        begin
            dec_found = (sel_str ? has_str_reg : has_res_reg) && cmp_lt;
            dec_idx   = sel_str ? str_idx_reg : res_idx_reg;
        end
        else if (stream_hit && has_str_reg && cmp_lt)
        begin
            dec_found = 1'b1;
            dec_idx   = str_idx_reg;
        end
        else if (!stream_hit && table_full && has_res_reg && cmp_lt)
        begin
            dec_found = 1'b1;
            dec_idx   = res_idx_reg;
        end
        else
        begin
            dec_found = has_free_reg;
            dec_idx   = free_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            limit_reg        <= STREAM_LIMIT_RST;
            is_write_reg     <= 1'b0;
            req_prio_reg     <= '0;
            req_stream_reg   <= 1'b0;
            req_required_reg <= 1'b0;
            scan_idx_reg     <= '0;
            pipe_valid_reg   <= 1'b0;
            pipe_idx_reg     <= '0;
            has_free_reg     <= 1'b0;
            free_idx_reg     <= '0;
            has_res_reg      <= 1'b0;
            res_idx_reg      <= '0;
            res_prio_reg     <= '0;
            has_str_reg      <= 1'b0;
            str_idx_reg      <= '0;
            str_prio_reg     <= '0;
            used_reg         <= '0;
            str_cnt_reg      <= '0;
            res_ge_str_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            chosen_reg       <= '0;
            used_out_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end

            if (out_valid_reg && !out_stall && (state_reg != ST_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            // accumulate one slot per cycle from the registered table read
            if (pipe_valid_reg)
            begin
                if (!rd_entry.in_use)
                begin
                    if (!has_free_reg)
                    begin
                        has_free_reg <= 1'b1;
                        free_idx_reg <= pipe_idx_reg;
                    end
                end
                else
                begin
                    used_reg <= used_reg + CNT_W'(1);
                    if (rd_resident)
                    begin
                        if (!has_res_reg || cmp_lt)
                        begin
                            has_res_reg  <= 1'b1;
                            res_idx_reg  <= pipe_idx_reg;
                            res_prio_reg <= rd_entry.priority_val;
                        end
                    end
                    else
                    begin
                        if (!has_str_reg || cmp_lt)
                        begin
                            has_str_reg  <= 1'b1;
                            str_idx_reg  <= pipe_idx_reg;
                            str_prio_reg <= rd_entry.priority_val;
                        end
                        str_cnt_reg <= str_cnt_reg + CNT_W'(1);
                    end
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        is_write_reg     <= (op == OP_WRITE);
                        req_prio_reg     <= request_priority;
                        req_stream_reg   <= request_streaming;
                        req_required_reg <= request_required;
                        scan_idx_reg     <= '0;
                        has_free_reg     <= 1'b0;
                        has_res_reg      <= 1'b0;
                        has_str_reg      <= 1'b0;
                        used_reg         <= '0;
                        str_cnt_reg      <= '0;
                        state_reg        <= (op == OP_WRITE) ? ST_RESULT : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    pipe_valid_reg <= 1'b1;
                    pipe_idx_reg   <= scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_LAST;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end
                end
                ST_LAST:
                begin
                    pipe_valid_reg <= 1'b0;
                    state_reg      <= ST_CMP;
                end
                ST_CMP:
                begin
                    res_ge_str_reg <= !cmp_lt;
                    state_reg      <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (is_write_reg)
                        begin
                            found_reg    <= 1'b0;
                            chosen_reg   <= '0;
                            used_out_reg <= '0;
                        end
                        else
                        begin
                            found_reg    <= dec_found;
                            chosen_reg   <= dec_found ? INDEX_W'(dec_idx) : '0;
                            used_out_reg <= COUNT_W'(used_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot_found  = found_reg;
    assign chosen_slot = chosen_reg;
    assign used_count  = used_out_reg;

    `VBSS_ASSERT(a_free_matches_count, (state_reg == ST_CMP) |-> (has_free_reg == !table_full), "free slot flag disagrees with used count")
    `VBSS_ASSERT(a_stream_within_used, (str_cnt_reg <= used_reg) && (used_reg <= ALL_SLOTS), "slot counts out of range")
    `VBSS_ASSERT(a_no_slot_zero_index, (out_valid_reg && !found_reg) |-> (chosen_reg == '0), "chosen slot nonzero with no slot found")
    `VBSS_ASSERT_NEXT(a_accept_leaves_idle, in_accept, (state_reg != ST_IDLE), "accepted word did not start work")

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the voice slot allocator: directed and random slot writes and requests checked against a table model.
module tb_top;
    import vbss_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] slot_index;
        logic               slot_in_use;
        logic [PRIO_W-1:0]  slot_priority;
        logic               slot_streaming;
        logic               slot_group_secondary;
        logic [PRIO_W-1:0]  request_priority;
        logic               request_streaming;
        logic               request_required;
    } voice_word_t;

    typedef struct packed {
        logic               slot_found;
        logic [INDEX_W-1:0] chosen_slot;
        logic [COUNT_W-1:0] used_count;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic slot_found;
    logic [INDEX_W-1:0] chosen_slot;
    logic [COUNT_W-1:0] used_count;
    voice_word_t drv_word = '0;

    voice_word_t pending_words[$];
    alloc_result_t expected_results[$];
    slot_entry_t slot_table[SLOTS];
    logic [LIMIT_W-1:0] stream_limit = STREAM_LIMIT_RST;
    int send_wait = 0;
    int recv_wait = 0;
    bit quiet_send = 1'b0;
    bit quiet_recv = 1'b0;
    int fail_count = 0;
    alloc_result_t want;
    alloc_result_t got;

    voice_buffer_steal_select_top DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .op                   (drv_word.op),
        .slot_index           (drv_word.slot_index),
        .slot_in_use          (drv_word.slot_in_use),
        .slot_priority        (drv_word.slot_priority),
        .slot_streaming       (drv_word.slot_streaming),
        .slot_group_secondary (drv_word.slot_group_secondary),
        .request_priority     (drv_word.request_priority),
        .request_streaming    (drv_word.request_streaming),
        .request_required     (drv_word.request_required),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .slot_found           (slot_found),
        .chosen_slot          (chosen_slot),
        .used_count           (used_count)
    );

    always #4 clk = ~clk;

    function automatic alloc_result_t predict_alloc(input voice_word_t w);
        alloc_result_t r;
        logic has_free, has_res, has_str, has_victim;
        int free_idx, res_idx, str_idx, victim;
        int used, stream_cnt;
        r = '0;
        if (w.op == OP_WRITE)
        begin
            if (w.slot_index < SLOTS)
            begin
                slot_table[w.slot_index].in_use       = w.slot_in_use;
                slot_table[w.slot_index].priority_val = w.slot_priority;
                slot_table[w.slot_index].streaming    = w.slot_streaming;
                slot_table[w.slot_index].secondary    = w.slot_group_secondary;
            end
            return r;
        end
        has_free = 1'b0;
        has_res = 1'b0;
        has_str = 1'b0;
        free_idx = 0;
        res_idx = 0;
        str_idx = 0;
        used = 0;
        stream_cnt = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_table[i].in_use)
            begin
                if (!has_free)
                begin
                    has_free = 1'b1;
                    free_idx = i;
                end
            end
            else
            begin
                used++;
                if (!slot_table[i].streaming || slot_table[i].secondary)
                begin
                    if (!has_res || slot_table[i].priority_val < slot_table[res_idx].priority_val)
                    begin
                        has_res = 1'b1;
                        res_idx = i;
                    end
                end
                else
                begin
                    if (!has_str || slot_table[i].priority_val < slot_table[str_idx].priority_val)
                    begin
                        has_str = 1'b1;
                        str_idx = i;
                    end
                    stream_cnt++;
                end
            end
        end
        r.used_count = used[COUNT_W-1:0];
        victim = -1;
        if (w.request_required && has_free)
            victim = free_idx;
        else if (w.request_required && used == SLOTS)
        begin
            has_victim = has_res;
            victim = res_idx;
            if (!has_res || (has_str &&
                slot_table[res_idx].priority_val >= slot_table[str_idx].priority_val))
            begin
                has_victim = has_str;
                victim = str_idx;
            end
            if (!(has_victim && slot_table[victim].priority_val < w.request_priority))
                victim = -1;
        end
        else if (w.request_streaming && stream_cnt == stream_limit)
        begin
            if (has_str && slot_table[str_idx].priority_val < w.request_priority)
                victim = str_idx;
            else if (has_free)
                victim = free_idx;
        end
        else if (used == SLOTS && has_res &&
                 slot_table[res_idx].priority_val < w.request_priority)
            victim = res_idx;
        else if (has_free)
            victim = free_idx;
        if (victim >= 0)
        begin
            r.slot_found = 1'b1;
            r.chosen_slot = victim[INDEX_W-1:0];
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_alloc(drv_word));
                send_wait = quiet_send ? 0 : $urandom_range(0, 9);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    drv_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.slot_found = slot_found;
                got.chosen_slot = chosen_slot;
                got.used_count = used_count;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: found=%0d slot=%0d used=%0d",
                                 got.slot_found, got.chosen_slot, got.used_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.slot_found !== want.slot_found ||
                        got.chosen_slot !== want.chosen_slot ||
                        got.used_count !== want.used_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected found=%0d slot=%0d used=%0d, got found=%0d slot=%0d used=%0d",
                                     want.slot_found, want.chosen_slot, want.used_count,
                                     got.slot_found, got.chosen_slot, got.used_count);
                    end
                end
                recv_wait = quiet_recv ? 0 : $urandom_range(0, 9);
            end
            if (recv_wait > 0)
            begin
                out_stall <= 1'b1;
                recv_wait--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [PRIO_W-1:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'hFFFF_FFFE;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic push_write(input logic [INDEX_W-1:0] idx, input logic in_use,
                              input logic [PRIO_W-1:0] pv, input logic strm, input logic sec);
        voice_word_t w;
        w.op = OP_WRITE;
        w.slot_index = idx;
        w.slot_in_use = in_use;
        w.slot_priority = pv;
        w.slot_streaming = strm;
        w.slot_group_secondary = sec;
        w.request_priority = $urandom;
        w.request_streaming = 1'($urandom_range(0, 1));
        w.request_required = 1'($urandom_range(0, 1));
        pending_words.push_back(w);
    endtask

    task automatic push_request(input logic [PRIO_W-1:0] pv, input logic strm,
                                input logic req);
        voice_word_t w;
        w.op = OP_REQUEST;
        w.slot_index = INDEX_W'($urandom_range(0, SLOTS - 1));
        w.slot_in_use = 1'($urandom_range(0, 1));
        w.slot_priority = $urandom;
        w.slot_streaming = 1'($urandom_range(0, 1));
        w.slot_group_secondary = 1'($urandom_range(0, 1));
        w.request_priority = pv;
        w.request_streaming = strm;
        w.request_required = req;
        pending_words.push_back(w);
    endtask

    task automatic gen_phase(input int n);
        int made, pick, base, str_pct, sec_pct;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 14);
            if (pick == 0)
            begin
                // load the whole table, then hit it with requests
                str_pct = $urandom_range(0, 2) * 50;
                sec_pct = chance(50) ? 0 : 25;
                base = $urandom_range(0, SLOTS - 1);
                for (int k = 0; k < SLOTS; k++)
                    push_write(INDEX_W'((base + k) % SLOTS), 1'b1, rand_prio(),
                               chance(str_pct), chance(sec_pct));
                for (int k = $urandom_range(4, 8); k > 0; k--)
                    push_request(rand_prio(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                made += SLOTS + 4;
            end
            else if (pick <= 6)
            begin
                push_write(INDEX_W'($urandom_range(0, SLOTS - 1)), chance(75), rand_prio(),
                           1'($urandom_range(0, 1)), chance(30));
                made++;
            end
            else
            begin
                push_request(rand_prio(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        stream_limit = v;
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] limits[7];
        limits = '{5'd0, 5'd16, 5'd15, 5'd1, 5'd2, 5'd0, 5'd4};
        limits[5] = LIMIT_W'($urandom_range(0, 16));
        for (int i = 0; i < SLOTS; i++)
            slot_table[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_limit(5'd4);
        @(negedge clk);

        // empty table, then a full one with five streaming voices, one of them secondary
        push_request(32'h0, 1'b0, 1'b1);
        push_request(32'hFFFF_FFFF, 1'b1, 1'b0);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i < 4)
                push_write(INDEX_W'(i), 1'b1, (i == 0) ? 5 : (i == 3) ? 9 : 3, 1'b1, 1'b0);
            else if (i == 4)
                push_write(INDEX_W'(i), 1'b1, 2, 1'b1, 1'b1);
            else if (i == 15)
                push_write(INDEX_W'(i), 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1);
            else
                push_write(INDEX_W'(i), 1'b1, (i % 3) + 2, 1'b0, 1'b0);
        end
        push_request(32'hFFFF_FFFF, 1'b0, 1'b1);
        push_request(32'h0, 1'b0, 1'b1);
        push_request(32'h4, 1'b1, 1'b0);
        push_request(32'h3, 1'b1, 1'b0);
        push_request(32'd100, 1'b0, 1'b0);
        push_write(4'd7, 1'b0, 32'h0, 1'b0, 1'b0);
        push_request(32'h0, 1'b0, 1'b0);
        push_request(32'h0, 1'b1, 1'b1);
        wait_drained();

        foreach (limits[p])
        begin
            write_limit(limits[p]);
            @(negedge clk);
            quiet_send = chance(25);
            quiet_recv = chance(25);
            gen_phase(72);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/vbss_pkg.sv
design/vbss_slot_table.sv
design/voice_buffer_steal_select_top.sv
verif/tb_top.sv
